[sv/sawtc_pkg.sv]
`timescale 1ns / 1ps
package sawtc_pkg;
  localparam int Ways = 8;
  localparam int WayW = 3;
  localparam int SetW = 7;
  localparam int TagW = 7;
  localparam int LineW = 10;
  localparam int RowW = 13;
  localparam int MemRowW = 17;
  localparam int AddrW = 20;
  localparam logic [15:0] LfsrSeed = 16'hACE1;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_TAG   = 11'b00000000010,
    ST_LOOK  = 11'b00000000100,
    ST_FILL  = 11'b00000001000,
    ST_FLAST = 11'b00000010000,
    ST_RD    = 11'b00000100000,
    ST_RDW   = 11'b00001000000,
    ST_WR    = 11'b00010000000,
    ST_NEXT  = 11'b00100000000,
    ST_DONE  = 11'b01000000000,
    ST_CLR   = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic            we;
    logic [RowW-1:0] addr;
    logic [63:0]     wdata;
    logic [7:0]      be;
  } ram_req_t;

  typedef struct packed {
    logic              we;
    logic [MemRowW-1:0] addr;
    logic [63:0]       wdata;
    logic [7:0]        be;
  } mem_req_t;
endpackage

[sv/sawtc_data_ram.sv]
`timescale 1ns / 1ps
module sawtc_data_ram
  import sawtc_pkg::*;
(
  input  logic        clk,
  input  ram_req_t    req,
  output logic [63:0] rdata
);
  logic [63:0] mem [0:(1<<RowW)-1];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (req.we && req.be[i]) mem[req.addr][8*i +: 8] <= req.wdata[8*i +: 8];
    end
    rdata <= mem[req.addr];
  end
endmodule

[sv/sawtc_back_mem.sv]
`timescale 1ns / 1ps
module sawtc_back_mem
  import sawtc_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [63:0] rdata
);
  logic [63:0] mem [0:(1<<MemRowW)-1];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (req.we && req.be[i]) mem[req.addr][8*i +: 8] <= req.wdata[8*i +: 8];
    end
    rdata <= mem[req.addr];
  end
endmodule

[sv/set_assoc_write_through_cache.sv]
`timescale 1ns / 1ps
// 8-way, 128-set write-through cache with 64-byte lines over a 1 MiB backing
// memory held inside the block. Pulse start while busy is low; one result
// appears for one cycle with out_valid and cannot be stalled. After reset the
// block stays busy while it clears the valid memory, one set per cycle. A hit
// write runs tag, lookup, write and next steps before its result, a hit read
// tag, lookup, read, read-wait and next; bytes that straddle two 64-bit words
// repeat the write step, or the read and read-wait steps. Each line miss adds
// fill steps for the eight-word line copy from the single-port backing memory;
// an access crossing a line runs tag, lookup, access and next steps again for
// the second line. busy falls in the cycle after the result. Tags and valid
// bits live in memories read one set per cycle; only the tags are one-port.
module set_assoc_write_through_cache
  import sawtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [AddrW-1:0]  in_address,
  input  logic [2:0]        in_length,
  input  logic [31:0]       in_write_data,
  output logic              out_valid,
  output logic [31:0]       out_read_data,
  output logic              out_hit
);
  state_t state_r, state_nxt;
  logic [Ways-1:0] valid_mem [0:(1<<SetW)-1];
  logic [Ways-1:0] vld_rd;
  logic [TagW*Ways-1:0] tag_mem [0:(1<<SetW)-1];
  logic [TagW*Ways-1:0] tag_rd;
  logic [SetW-1:0] clr_r;
  logic [15:0] lfsr_r;
  logic func_r;
  logic [AddrW-1:0] addr_r;
  logic [2:0] len_r;
  logic [31:0] wd_r, rd_r;
  logic hit_r, seg_r;
  logic [WayW-1:0] way_r;
  logic [2:0] cnt_r;
  logic [2:0] seg_n;
  logic [AddrW-1:0] seg_a;
  logic [63:0] ram_rd, mem_rd;
  ram_req_t ram_req;
  mem_req_t mem_req;

  // Segment geometry: first segment at addr_r, second at next line.
  logic [2:0] len_s, first_n;
  logic [6:0] room;
  always_comb begin
    len_s = (len_r > 3'd4) ? 3'd4 : len_r;
    room = 7'd64 - {1'b0, addr_r[5:0]};
    first_n = (room < {4'd0, len_s}) ? room[2:0] : len_s;
    seg_n = seg_r ? len_s - first_n : first_n;
    seg_a = seg_r ? {addr_r[AddrW-1:6] + 14'd1, 6'd0} : addr_r;
  end
  logic [2:0] boff;
  assign boff = seg_r ? first_n : 3'd0;
  logic [SetW-1:0] set_i;
  logic [TagW-1:0] tag_i;
  assign set_i = seg_a[12:6];
  assign tag_i = seg_a[19:13];

  logic match;
  logic [WayW-1:0] mway, fway;
  logic free;
  logic [15:0] lfsr_adv;
  always_comb begin
    match = 1'b0; mway = '0; free = 1'b0; fway = '0;
    for (int w = Ways-1; w >= 0; w--) begin
      if (vld_rd[w] && tag_rd[TagW*w +: TagW] == tag_i) begin
        match = 1'b1; mway = WayW'(w);
      end
      if (!vld_rd[w]) begin
        free = 1'b1; fway = WayW'(w);
      end
    end
    lfsr_adv = {lfsr_r[0]^lfsr_r[2]^lfsr_r[3]^lfsr_r[5], lfsr_r[15:1]};
  end
  logic [WayW-1:0] way_r_sel;
  assign way_r_sel = free ? fway : lfsr_adv[WayW-1:0];
  logic [Ways-1:0] way_bit;
  assign way_bit = {{(Ways-1){1'b0}}, 1'b1} << way_r_sel;

  // Per-byte placement of this segment within its 64-bit word(s).
  logic [5:0] off;
  logic [63:0] wword;
  logic [7:0] wbe;
  logic [6:0] bsum;
  always_comb begin
    off = seg_a[5:0];
    wword = '0; wbe = '0;
    for (int j = 0; j < 4; j++) begin
      bsum = {1'b0, off} + 7'(j);
      if (3'(j) < seg_n && bsum[6:3] == {1'b0, off[5:3]}) begin
        wbe[bsum[2:0]] = 1'b1;
        wword[8*bsum[2:0] +: 8] = wd_r[8*(j+boff) +: 8];
      end
    end
  end
  // Word index of the segment's bytes; a segment spans at most two words.
  logic span2;
  logic [6:0] lastb;
  assign lastb = {1'b0, off} + {4'd0, seg_n} - 7'd1;
  assign span2 = lastb[5:3] != off[5:3];
  logic [63:0] wword2;
  logic [7:0] wbe2;
  logic [6:0] bsum2;
  always_comb begin
    wword2 = '0; wbe2 = '0;
    for (int j = 0; j < 4; j++) begin
      bsum2 = {1'b0, off} + 7'(j);
      if (3'(j) < seg_n && bsum2[5:3] != off[5:3]) begin
        wbe2[bsum2[2:0]] = 1'b1;
        wword2[8*bsum2[2:0] +: 8] = wd_r[8*(j+boff) +: 8];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ram_req = '0;
    mem_req = '0;
    ram_req.addr = {set_i, way_r, off[5:3]};
    mem_req.addr = {seg_a[19:6], cnt_r};
    case (state_r)
      ST_CLR: if (&clr_r) state_nxt = ST_IDLE;
      ST_IDLE: if (start) state_nxt = ST_TAG;
      ST_TAG: begin
        state_nxt = (seg_n == 3'd0) ? ST_DONE : ST_LOOK;
        mem_req.addr = {seg_a[19:6], 3'd0};
      end
      ST_LOOK: state_nxt = match ? (func_r ? ST_WR : ST_RD) : ST_FILL;
      ST_FILL: begin
        ram_req.we = cnt_r != 3'd0 || 1'b0;
        mem_req.addr = {seg_a[19:6], cnt_r};
        ram_req.addr = {set_i, way_r, cnt_r - 3'd1};
        ram_req.wdata = mem_rd; ram_req.be = 8'hFF;
        if (cnt_r == 3'd7) state_nxt = ST_FLAST;
      end
      ST_FLAST: begin
        ram_req.we = 1'b1; ram_req.addr = {set_i, way_r, 3'd7};
        ram_req.wdata = mem_rd; ram_req.be = 8'hFF;
        state_nxt = func_r ? ST_WR : ST_RD;
      end
      ST_RD: begin
        ram_req.addr = {set_i, way_r, cnt_r[0] ? lastb[5:3] : off[5:3]};
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        ram_req.addr = {set_i, way_r, lastb[5:3]};
        state_nxt = (span2 && !cnt_r[0]) ? ST_RD : ST_NEXT;
      end
      ST_WR: begin
        ram_req.we = 1'b1; mem_req.we = 1'b1;
        ram_req.addr = {set_i, way_r, cnt_r[0] ? lastb[5:3] : off[5:3]};
        mem_req.addr = {seg_a[19:6], cnt_r[0] ? lastb[5:3] : off[5:3]};
        ram_req.wdata = cnt_r[0] ? wword2 : wword;
        ram_req.be = cnt_r[0] ? wbe2 : wbe;
        mem_req.wdata = ram_req.wdata; mem_req.be = ram_req.be;
        state_nxt = (span2 && !cnt_r[0]) ? ST_WR : ST_NEXT;
      end
      ST_NEXT: state_nxt = (!seg_r && len_s != first_n) ? ST_TAG : ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  sawtc_data_ram u_data (.clk(clk), .req(ram_req), .rdata(ram_rd));
  sawtc_back_mem u_mem (.clk(clk), .req(mem_req), .rdata(mem_rd));

  always_ff @(posedge clk) begin
    tag_rd <= tag_mem[set_i];
    vld_rd <= valid_mem[set_i];
    if (state_r == ST_CLR) begin
      valid_mem[clr_r] <= '0;
    end else if (state_r == ST_LOOK && !match) begin
      valid_mem[set_i] <= vld_rd | way_bit;
      tag_mem[set_i][TagW*way_r_sel +: TagW] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      lfsr_r <= LfsrSeed;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_LOOK && !match && !free) lfsr_r <= lfsr_adv;
    end
  end

  always_ff @(posedge clk) begin
    logic [6:0] rsum;
    case (state_r)
      ST_IDLE: if (start) begin
        func_r <= in_func; addr_r <= in_address; len_r <= in_length;
        wd_r <= in_write_data; rd_r <= '0; hit_r <= 1'b1; seg_r <= 1'b0;
      end
      ST_TAG: cnt_r <= '0;
      ST_LOOK: begin
        way_r <= match ? mway : way_r_sel;
        if (!match) hit_r <= 1'b0;
        cnt_r <= match ? 3'd0 : 3'd1;
      end
      ST_FILL: cnt_r <= cnt_r + 3'd1;
      ST_FLAST: cnt_r <= '0;
      ST_RDW: begin
        for (int j = 0; j < 4; j++) begin
          rsum = {1'b0, off} + 7'(j);
          if (3'(j) < seg_n && ((rsum[5:3] == off[5:3]) != cnt_r[0]))
            rd_r[8*(j+boff) +: 8] <= ram_rd[8*rsum[2:0] +: 8];
        end
        cnt_r <= cnt_r + 3'd1;
      end
      ST_WR: cnt_r <= cnt_r + 3'd1;
      ST_NEXT: begin seg_r <= 1'b1; cnt_r <= '0; end
      default: ;
    endcase
  end

  assign busy = state_r != ST_IDLE;
  assign out_valid = state_r == ST_DONE;
  assign out_read_data = func_r ? 32'd0 : rd_r;
  assign out_hit = hit_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_lfsr_nz: assert property (@(posedge clk) disable iff (!rst_n) lfsr_r != 16'd0)
    else $error("lfsr stuck at zero");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result while idle");
  a_one_res: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result repeated");
endmodule

[bench/tb_set_assoc_write_through_cache.sv]
`timescale 1ns / 1ps
module tb_set_assoc_write_through_cache;
  import sawtc_pkg::*;

  localparam int FUNC_READ = 0;
  localparam int FUNC_WRITE = 1;
  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_func = 1'b0;
  logic [AddrW-1:0] in_address = '0;
  logic [2:0]       in_length = '0;
  logic [31:0]      in_write_data = '0;
  logic             out_valid;
  logic [31:0]      out_read_data;
  logic             out_hit;

  typedef struct {
    bit [31:0] read_data;
    bit        hit;
  } word_result_t;

  typedef struct {
    bit [AddrW-1:0] addr;
    bit [2:0]       len;
  } access_t;

  word_result_t expected_words[$];
  access_t      written_spans[$];
  int           errors = 0;
  int           cycles = 0;
  bit           quiet = 1'b0;

  bit             line_ok[Ways << SetW];
  bit [TagW-1:0]  line_tag_q[Ways << SetW];
  bit [7:0]       line_byte_q[Ways << SetW][64];
  bit [7:0]       mem_byte_q[1 << AddrW];
  bit             mem_known[1 << AddrW];
  bit [15:0]      victim_state = LfsrSeed;

  set_assoc_write_through_cache dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_set_assoc_write_through_cache failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        word_result_t e;
        e = expected_words.pop_front();
        if (out_read_data !== e.read_data)
          report_mismatch($sformatf("read_data %h, want %h", out_read_data, e.read_data));
        if (out_hit !== e.hit)
          report_mismatch($sformatf("hit %b, want %b", out_hit, e.hit));
      end
    end
  end

  function automatic int find_line(input bit [AddrW-1:0] b, inout bit all_hit);
    int first;
    int pick;
    bit [TagW-1:0] tg;
    bit fb;
    first = int'(b[12:6]) * Ways;
    tg = b[19:13];
    pick = -1;
    for (int w = 0; w < Ways; w++) begin
      if (line_ok[first + w]) begin
        if (line_tag_q[first + w] == tg) return first + w;
      end else if (pick < 0) begin
        pick = first + w;
      end
    end
    all_hit = 1'b0;
    if (pick < 0) begin
      fb = victim_state[0] ^ victim_state[2] ^ victim_state[3] ^ victim_state[5];
      victim_state = {fb, victim_state[15:1]};
      pick = first + int'(victim_state[WayW-1:0]);
    end
    for (int k = 0; k < 64; k++)
      line_byte_q[pick][k] = mem_byte_q[{b[19:6], 6'd0} + k];
    line_ok[pick] = 1'b1;
    line_tag_q[pick] = tg;
    return pick;
  endfunction

  function automatic word_result_t cache_access(input bit wr, input bit [AddrW-1:0] a,
                                                input bit [2:0] len, input bit [31:0] wd);
    word_result_t r;
    int n;
    int li;
    bit [AddrW-1:0] b;
    n = (len > 4) ? 4 : int'(len);
    r.read_data = '0;
    r.hit = 1'b1;
    li = 0;
    if (wr) begin
      for (int j = 0; j < n; j++) begin
        b = a + j;
        mem_byte_q[b] = wd[8*j +: 8];
        mem_known[b] = 1'b1;
      end
    end
    for (int j = 0; j < n; j++) begin
      b = a + j;
      if (j == 0 || b[5:0] == 0) li = find_line(b, r.hit);
      if (wr) line_byte_q[li][b[5:0]] = wd[8*j +: 8];
      else r.read_data[8*j +: 8] = line_byte_q[li][b[5:0]];
    end
    return r;
  endfunction

  function automatic bit bytes_known(input bit [AddrW-1:0] a, input bit [2:0] len);
    int n;
    n = (len > 4) ? 4 : int'(len);
    for (int j = 0; j < n; j++)
      if (!mem_known[AddrW'(a + j)]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_word(input bit wr, input bit [AddrW-1:0] a, input bit [2:0] len,
                           input bit [31:0] wd);
    access_t s;
    if (!quiet && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= wr;
    in_address <= a;
    in_length <= len;
    in_write_data <= wd;
    do @(posedge clk); while (busy);
    expected_words.push_back(cache_access(wr, a, len, wd));
    if (wr && len != 0) begin
      s.addr = a;
      s.len = len;
      written_spans.push_back(s);
    end
  endtask

  task automatic test_boundaries();
    send_word(FUNC_WRITE, 20'h00000, 3'd4, 32'hFFFF_FFFF);
    send_word(FUNC_READ, 20'h00000, 3'd4, 32'h0);
    send_word(FUNC_WRITE, 20'hFFFFF, 3'd4, 32'hA5C3_1E77);
    send_word(FUNC_READ, 20'hFFFFE, 3'd0, 32'hFFFF_FFFF);
    send_word(FUNC_WRITE, 20'hFFFFE, 3'd0, 32'hFFFF_FFFF);
    send_word(FUNC_READ, 20'hFFFFF, 3'd4, 32'h0);
    send_word(FUNC_WRITE, 20'h0003E, 3'd7, 32'h1234_5678);
    send_word(FUNC_READ, 20'h0003E, 3'd5, 32'h0);
    send_word(FUNC_WRITE, 20'h7FFC1, 3'd5, 32'hFFFF_FFFF);
    send_word(FUNC_READ, 20'h7FFC1, 3'd6, 32'h0);
    send_word(FUNC_READ, 20'h0003E, 3'd1, 32'h0);
    send_word(FUNC_WRITE, 20'h00040, 3'd2, 32'h0);
    send_word(FUNC_READ, 20'h0003F, 3'd2, 32'h0);
  endtask

  task automatic test_replacement();
    for (int t = 0; t < 10; t++)
      send_word(FUNC_WRITE, {7'(t * 13), 7'd5, 6'd8}, 3'd4, $urandom);
    for (int t = 0; t < 6; t++)
      send_word(FUNC_READ, {7'(t * 13 + 13), 7'd5, 6'd8}, 3'd4, 32'h0);
  endtask

  task automatic test_random(input int count);
    bit wr;
    bit [AddrW-1:0] a;
    bit [2:0] len;
    bit [6:0] hot_sets[4] = '{7'd0, 7'd1, 7'd63, 7'd127};
    access_t s;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < 2 * count / 3);
      wr = ($urandom_range(99) < 45);
      len = $urandom_range(7);
      if ($urandom_range(99) < 15)
        a = $urandom;
      else
        a = {7'($urandom_range(0, 20) * 6), hot_sets[$urandom_range(3)],
             ($urandom_range(1) != 0) ? 6'($urandom_range(59, 63)) : 6'($urandom)};
      if (!wr && !bytes_known(a, len)) begin
        s = written_spans[$urandom_range(written_spans.size() - 1)];
        a = s.addr;
        len = $urandom_range(1) ? s.len : 3'($urandom_range(1, (s.len > 4) ? 4 : s.len));
      end
      send_word(wr, a, len, $urandom);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_boundaries();
    test_replacement();
    test_random(680);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("tb_set_assoc_write_through_cache passed");
    else
      $display("tb_set_assoc_write_through_cache failed");
    $finish;
  end
endmodule
